// ----- hw/rtl/bbms_pkg.sv -----
// Shared types and constants for the bzip2 block marker scanner.
`timescale 1ns / 1ps
`default_nettype none
package bbms_pkg;

  localparam logic [47:0] MAGIC_BLOCK = 48'h3141_5926_5359;
  localparam logic [47:0] MAGIC_END   = 48'h1772_4538_5090;
  localparam int unsigned MARKER_LAG  = 49;
  localparam int unsigned SIZE_BIAS   = 88;
  localparam logic [15:0] MAX_BLOCKS  = 16'd50000;

  localparam logic [31:0] DEFAULT_MAX_BLOCK_BITS = 32'd8192000;
  localparam logic [15:0] DEFAULT_MIN_BLOCK_BITS = 16'd130;

  // Configuration register indexes.
  localparam logic REG_MAX_BLOCK_BITS = 1'b0;
  localparam logic REG_MIN_BLOCK_BITS = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_BLOCK  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [39:0] block_start_bit;
    logic [39:0] block_end_bit;
    logic [36:0] image_bytes;
    logic        last;
  } out_req_t;

  typedef enum logic [1:0] {
    OP_BYTE = 2'b01,
    OP_END  = 2'b10
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } cmd_t;

  // Up to two results produced by one byte, first one always valid.
  typedef struct packed {
    logic     two;
    out_req_t first;
    out_req_t second;
  } pair_t;

  typedef struct packed {
    logic [31:0] max_block_bits;
    logic [15:0] min_block_bits;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bbms_fifo.sv -----
// Small register queue with registered head, used between the scanner stages.
`timescale 1ns / 1ps
`default_nettype none
module bbms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bbms_front.sv -----
// Front end: takes byte requests, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module bbms_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  bbms_pkg::in_req_t byte_req,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output bbms_pkg::cmd_t    cmd
);
  import bbms_pkg::*;

  cmd_t cmd_in;
  logic full;
  logic empty;

  always_comb begin
    cmd_in.op        = byte_req.end_of_data ? OP_END : OP_BYTE;
    cmd_in.data_byte = byte_req.data_byte;
  end

  assign byte_stall = full;
  assign cmd_valid  = !empty;

  bbms_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .push     (byte_valid),
    .push_data(cmd_in),
    .full     (full),
    .pop      (cmd_pop),
    .pop_data (cmd),
    .empty    (empty)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/bbms_core.sv -----
// Back end: advances the bit window by one byte a cycle while the pair queue has room, and builds results.
`timescale 1ns / 1ps
`default_nettype none
module bbms_core #(
  parameter int POSITION_BITS = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  bbms_pkg::cfg_t  cfg,
  input  logic            cmd_valid,
  input  bbms_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  input  logic            pair_ready,
  output logic            pair_push,
  output bbms_pkg::pair_t pair
);
  import bbms_pkg::*;

  localparam int P  = POSITION_BITS;
  localparam int SW = (P < 64) ? P + 1 : 64;

  logic [47:0]  win;
  logic [P-1:0] cnt;
  logic [P-1:0] bstart;
  logic [P-1:0] lpos;
  logic [15:0]  mcnt;

  logic [47:0]  win_next;
  logic [P-1:0] cnt_next;
  logic [P-1:0] bstart_next;
  logic [P-1:0] lpos_next;
  logic [15:0]  mcnt_next;

  // Per-bit views of the byte: entry i is the state after bit i+1.
  logic [55:0]  ext;
  logic [P-1:0] cnt_k  [8];
  logic [P-1:0] dist_k [8];
  logic [47:0]  win_k  [8];
  logic         over_k [8];
  logic         match_k[8];

  logic         found;
  logic         ev_over;
  logic [2:0]   ev_idx;
  logic [P-1:0] cnt_m;
  logic [P-1:0] pos;
  logic [SW-1:0] sum_last;
  logic [SW-1:0] sum_pos;

  logic     have_report;
  logic     have_verdict;
  logic     accept;
  logic     size_from_pos;
  logic     clear;
  out_req_t report_res;
  out_req_t verdict_res;

  assign ext     = {win, cmd.data_byte};
  assign cmd_pop = cmd_valid && pair_ready;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cnt_k[i]   = cnt + P'(i + 1);
      dist_k[i]  = cnt_k[i] - bstart;
      over_k[i]  = dist_k[i] > P'(cfg.max_block_bits);
      win_k[i]   = ext[54-i -: 48];
      match_k[i] = (win_k[i] == MAGIC_BLOCK) || (win_k[i] == MAGIC_END);
    end
  end

  // The earliest bit that either runs past the length limit or completes a marker.
  always_comb begin
    found   = 1'b0;
    ev_over = 1'b0;
    ev_idx  = '0;
    for (int i = 7; i >= 0; i--) begin
      if (over_k[i] || match_k[i]) begin
        found   = 1'b1;
        ev_over = over_k[i];
        ev_idx  = 3'(i);
      end
    end
  end

  always_comb begin
    cnt_m    = cnt_k[ev_idx];
    pos      = (cnt_m > P'(MARKER_LAG)) ? cnt_m - P'(MARKER_LAG) : '0;
    sum_last = SW'(lpos) + SW'(SIZE_BIAS);
    sum_pos  = SW'(pos) + SW'(SIZE_BIAS);
  end

  always_comb begin
    report_res                 = '0;
    report_res.result_kind     = KIND_BLOCK;
    report_res.block_start_bit = 40'(bstart);
    report_res.block_end_bit   = 40'(pos);
  end

  always_comb begin
    win_next      = win;
    cnt_next      = cnt;
    bstart_next   = bstart;
    lpos_next     = lpos;
    mcnt_next     = mcnt;
    have_report   = 1'b0;
    have_verdict  = 1'b0;
    accept        = 1'b0;
    size_from_pos = 1'b0;
    clear         = 1'b0;
    if (cmd_pop) begin
      case (cmd.op)
        OP_END: begin
          have_verdict = 1'b1;
          accept       = over_k[0] ? (mcnt >= 16'd1) : (mcnt >= 16'd2);
          clear        = 1'b1;
        end
        OP_BYTE: begin
          if (!found) begin
            win_next = win_k[7];
            cnt_next = cnt_k[7];
          end else if (ev_over) begin
            have_verdict = 1'b1;
            accept       = (mcnt >= 16'd1);
            clear        = 1'b1;
          end else begin
            have_report = (mcnt != '0) &&
                          ((pos - bstart) >= P'(cfg.min_block_bits));
            if (mcnt >= MAX_BLOCKS) begin
              have_verdict = 1'b1;
              clear        = 1'b1;
            end else if (32'(3'd7 - ev_idx) > cfg.max_block_bits) begin
              // The fresh block already runs too long before the byte ends.
              have_verdict  = 1'b1;
              accept        = 1'b1;
              size_from_pos = 1'b1;
              clear         = 1'b1;
            end else begin
              win_next    = win_k[7];
              cnt_next    = cnt_k[7];
              bstart_next = cnt_m;
              lpos_next   = pos;
              mcnt_next   = mcnt + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (clear) begin
      win_next    = '0;
      cnt_next    = '0;
      bstart_next = '0;
      lpos_next   = '0;
      mcnt_next   = '0;
    end
  end

  always_comb begin
    verdict_res = '0;
    if (accept) begin
      verdict_res.result_kind = KIND_ACCEPT;
      verdict_res.image_bytes = size_from_pos ? 37'(sum_pos >> 3) : 37'(sum_last >> 3);
    end else begin
      verdict_res.result_kind = KIND_REJECT;
    end
  end

  always_comb begin
    pair      = '0;
    pair_push = have_report || have_verdict;
    if (have_report) begin
      pair.first = report_res;
      if (have_verdict) begin
        pair.two         = 1'b1;
        pair.second      = verdict_res;
        pair.second.last = 1'b1;
      end else begin
        pair.first.last = 1'b1;
      end
    end else begin
      pair.first      = verdict_res;
      pair.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win    <= '0;
      cnt    <= '0;
      bstart <= '0;
      lpos   <= '0;
      mcnt   <= '0;
    end else begin
      win    <= win_next;
      cnt    <= cnt_next;
      bstart <= bstart_next;
      lpos   <= lpos_next;
      mcnt   <= mcnt_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bbms_emit.sv -----
// Output stage: queues result pairs and hands them out one request at a time.
`timescale 1ns / 1ps
`default_nettype none
module bbms_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               pair_push,
  input  bbms_pkg::pair_t    pair,
  output logic               pair_ready,
  output logic               result_valid,
  input  logic               result_stall,
  output bbms_pkg::out_req_t result_req
);
  import bbms_pkg::*;

  pair_t head;
  logic  full;
  logic  empty;
  logic  second;
  logic  second_next;
  logic  take;
  logic  pop;

  assign pair_ready   = !full;
  assign result_valid = !empty;
  assign result_req   = second ? head.second : head.first;
  assign take         = result_valid && !result_stall;
  assign pop          = take && (second || !head.two);

  always_comb begin
    second_next = second;
    if (take) begin
      second_next = !second && head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else begin
      second <= second_next;
    end
  end

  bbms_fifo #(
    .WIDTH($bits(pair_t)),
    .DEPTH(2)
  ) u_pair_q (
    .clk      (clk),
    .rst      (rst),
    .push     (pair_push),
    .push_data(pair),
    .full     (full),
    .pop      (pop),
    .pop_data (head),
    .empty    (empty)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/bzip2_block_marker_scanner.sv -----
// A byte request is held in the command queue, and its results are registered in the pair queue before they are taken.
// Throughput: one byte per cycle while no stall holds the flow; a byte that yields two results hands them out in turn.
// The rate is set by the one-byte-per-cycle scan stage, which steps all eight bits at once.
// Reset (rst, synchronous, active high) empties both queues, zeroes the scan state
// and restores max_block_bits to 8192000 and min_block_bits to 130.
`timescale 1ns / 1ps
`default_nettype none
module bzip2_block_marker_scanner #(
  parameter int POSITION_BITS = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  bbms_pkg::in_req_t  byte_req,
  output logic               result_valid,
  input  logic               result_stall,
  output bbms_pkg::out_req_t result_req,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import bbms_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  pair_t pair;
  logic  cmd_valid;
  logic  cmd_pop;
  logic  pair_ready;
  logic  pair_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_block_bits <= DEFAULT_MAX_BLOCK_BITS;
      cfg.min_block_bits <= DEFAULT_MIN_BLOCK_BITS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_BLOCK_BITS: cfg.max_block_bits <= cfg_data;
        REG_MIN_BLOCK_BITS: cfg.min_block_bits <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  bbms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_req  (byte_req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  bbms_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pair_ready(pair_ready),
    .pair_push (pair_push),
    .pair      (pair)
  );

  bbms_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .pair_push   (pair_push),
    .pair        (pair),
    .pair_ready  (pair_ready),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_req  (result_req)
  );

`ifndef SYNTHESIS
  // The second half of a two-result pair is ready right after the first is taken.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result_req.last |=> result_valid)
    else $error("second result of a pair missing");

  // Only a block report can be followed by another result of the same byte.
  a_first_is_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_req.last |-> result_req.result_kind == KIND_BLOCK)
    else $error("non-final result is not a block report");

  // A verdict always ends the results of its byte.
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    pair_push && pair.two |-> pair.second.result_kind != KIND_BLOCK)
    else $error("block report placed after another result");
`endif

endmodule
`default_nettype wire
